[hdl/rv32_instruction_execute_macros.svh]
// assertion helpers
`ifndef RV32_INSTRUCTION_EXECUTE_MACROS_SVH
`define RV32_INSTRUCTION_EXECUTE_MACROS_SVH
`define RVX_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RVX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[hdl/rvx_pkg.sv]
package rvx_pkg;
  localparam int MemBytes = 65536;
  localparam int MemAw = $clog2(MemBytes);
  localparam logic [6:0] OpR = 7'h33;
  localparam logic [6:0] OpI = 7'h13;
  localparam logic [6:0] OpSys = 7'h73;
  localparam logic [6:0] OpBr = 7'h63;
  localparam logic [6:0] OpJal = 7'h6F;
  localparam logic [6:0] OpSt = 7'h23;
  localparam logic [6:0] OpLd = 7'h03;
  localparam logic [6:0] OpLui = 7'h37;
  localparam logic [6:0] OpAuipc = 7'h17;
  localparam logic [6:0] F7Alt = 7'h20;
  localparam logic [2:0] EvNone = 3'd0;
  localparam logic [2:0] EvPrintInt = 3'd1;
  localparam logic [2:0] EvPrintStr = 3'd2;
  localparam logic [2:0] EvExit = 3'd3;
  localparam logic [2:0] EvPrintChar = 3'd4;
  localparam logic [2:0] EvBadCall = 3'd5;
  localparam logic [2:0] EvInvalid = 3'd6;

  typedef struct packed {
    logic clear;
    logic decode;
    logic rd_rs;
    logic div_start;
    logic mem_step;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic clear_last;
    logic need_div;
    logic div_done;
    logic mem_last;
    logic halted;
  } stat_t;
endpackage

[hdl/rvx_div.sv]
module rvx_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  input  logic        is_rem,
  output logic        done,
  output logic [31:0] result
);
  logic [31:0] quot;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic        neg_q;
  logic        neg_r;
  logic        rem_sel;
  logic        running;
  logic [32:0] trial;
  logic [32:0] shifted;
  logic [31:0] abs_a;
  logic [31:0] abs_b;

  assign abs_a = dividend[31] ? 32'(-dividend) : dividend;
  assign abs_b = divisor[31] ? 32'(-divisor) : divisor;
  assign shifted = {rem[31:0], quot[31]};
  assign trial = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count <= 6'd32;
        quot <= abs_a;
        rem <= '0;
        dvs <= abs_b;
        neg_q <= dividend[31] ^ divisor[31];
        neg_r <= dividend[31];
        rem_sel <= is_rem;
      end else if (running) begin
        if (trial[32]) begin
          rem <= shifted;
          quot <= {quot[30:0], 1'b0};
        end else begin
          rem <= trial;
          quot <= {quot[30:0], 1'b1};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (rem_sel) result = neg_r ? 32'(-rem[31:0]) : rem[31:0];
    else result = (neg_q && dvs != 0) ? 32'(-quot) : quot;
  end
endmodule

[hdl/rvx_datapath.sv]
module rvx_datapath (
  input  logic          clk,
  input  logic          rst,
  input  rvx_pkg::ctrl_t ctrl,
  output rvx_pkg::stat_t stat,
  input  logic          mode,
  input  logic [31:0]   instr_word,
  input  logic [15:0]   preload_addr,
  input  logic [7:0]    preload_byte,
  output logic [31:0]   next_pc,
  output logic          reg_written,
  output logic [4:0]    dest_index,
  output logic [31:0]   dest_value,
  output logic [2:0]    event_code,
  output logic [31:0]   event_value,
  output logic          halted
);
  logic [31:0] regs [32];
  logic [31:0] pc;
  logic        halt_flag;
  logic [7:0]  mem [rvx_pkg::MemBytes];
  logic [rvx_pkg::MemAw-1:0] clr_addr;
  logic [31:0] w;
  logic        pre;
  logic [15:0] p_addr;
  logic [7:0]  p_byte;
  logic [31:0] a, b, a0, a1;
  logic [1:0]  k;
  logic [31:0] ld_val;
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, addr, alu;
  logic        bad, wr, take, is_div;
  logic [63:0] mulp;
  logic [31:0] div_res;
  logic        div_done;
  logic [rvx_pkg::MemAw-1:0] byte_addr;
  logic [1:0]  nbytes;

  assign op = w[6:0];
  assign rd = w[11:7];
  assign f3 = w[14:12];
  assign f7 = w[31:25];
  assign imm_i = {{20{w[31]}}, w[31:20]};
  assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign addr = a + ((op == rvx_pkg::OpSt) ? imm_s : imm_i);
  assign byte_addr = rvx_pkg::MemAw'(addr + {30'd0, k});
  assign nbytes = (op == rvx_pkg::OpSt) ? f3[1:0] : 2'(f3[1:0]);
  assign is_div = op == rvx_pkg::OpR && f7 == 7'd1 && (f3 == 3'd4 || f3 == 3'd6);
  assign mulp = (f3 == 3'd1) ? 64'($signed(a) * $signed(b)) : 64'(a * b);

  rvx_div u_div (
    .clk(clk), .rst(rst), .start(ctrl.div_start), .dividend(a), .divisor(b),
    .is_rem(f3[1]), .done(div_done), .result(div_res)
  );

  assign stat.clear_last = &clr_addr;
  assign stat.need_div = is_div && !pre && !halt_flag;
  assign stat.div_done = div_done;
  assign stat.halted = halt_flag;
  assign stat.mem_last = !(op == rvx_pkg::OpLd || op == rvx_pkg::OpSt) || pre ||
      halt_flag || k == ((nbytes == 2'd0) ? 2'd0 : (nbytes == 2'd1) ? 2'd1 : 2'd3);

  always_comb begin
    alu = '0;
    bad = 1'b0;
    wr = 1'b0;
    take = 1'b0;
    case (op)
      rvx_pkg::OpR: begin
        wr = 1'b1;
        if (f7 == 7'd0) begin
          case (f3)
            3'd0: alu = a + b;
            3'd1: alu = a << b[4:0];
            3'd2: alu = {31'd0, $signed(a) < $signed(b)};
            3'd4: alu = a ^ b;
            3'd5: alu = a >> b[4:0];
            3'd6: alu = a | b;
            3'd7: alu = a & b;
            default: bad = 1'b1;
          endcase
        end else if (f7 == 7'd1) begin
          case (f3)
            3'd0: alu = mulp[31:0];
            3'd1: alu = mulp[63:32];
            3'd4: alu = (b == 0) ? 32'hFFFFFFFF : div_res;
            3'd6: alu = (b == 0) ? a : div_res;
            default: bad = 1'b1;
          endcase
        end else if (f7 == rvx_pkg::F7Alt) begin
          if (f3 == 3'd0) alu = a - b;
          else if (f3 == 3'd5) alu = 32'($signed(a) >>> b[4:0]);
          else bad = 1'b1;
        end else bad = 1'b1;
      end
      rvx_pkg::OpI: begin
        wr = 1'b1;
        case (f3)
          3'd0: alu = a + imm_i;
          3'd1: if (f7 == 7'd0) alu = a << w[24:20]; else bad = 1'b1;
          3'd2: alu = {31'd0, $signed(a) < $signed(imm_i)};
          3'd4: alu = a ^ imm_i;
          3'd5: begin
            if (f7 == 7'd0) alu = a >> w[24:20];
            else if (f7 == rvx_pkg::F7Alt) alu = 32'($signed(a) >>> w[24:20]);
            else bad = 1'b1;
          end
          3'd6: alu = a | imm_i;
          3'd7: alu = a & imm_i;
          default: bad = 1'b1;
        endcase
      end
      rvx_pkg::OpSys: ;
      rvx_pkg::OpBr: begin
        case (f3)
          3'd0: take = a == b;
          3'd1: take = a != b;
          3'd4: take = $signed(a) < $signed(b);
          3'd5: take = $signed(a) >= $signed(b);
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: bad = 1'b1;
        endcase
      end
      rvx_pkg::OpJal: begin
        wr = 1'b1;
        alu = pc + 32'd4;
      end
      rvx_pkg::OpSt: bad = f3 > 3'd2;
      rvx_pkg::OpLd: begin
        wr = 1'b1;
        case (f3)
          3'd0: alu = {{24{ld_val[7]}}, ld_val[7:0]};
          3'd1: alu = {{16{ld_val[15]}}, ld_val[15:0]};
          3'd2: alu = ld_val;
          3'd4: alu = {24'd0, ld_val[7:0]};
          3'd5: alu = {16'd0, ld_val[15:0]};
          default: bad = 1'b1;
        endcase
      end
      rvx_pkg::OpLui: begin
        wr = 1'b1;
        alu = {w[31:12], 12'd0};
      end
      rvx_pkg::OpAuipc: begin
        wr = 1'b1;
        alu = pc + {w[31:12], 12'd0};
      end
      default: bad = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) mem[clr_addr] <= '0;
    if (ctrl.decode) begin
      w <= instr_word;
      pre <= mode;
      p_addr <= preload_addr;
      p_byte <= preload_byte;
    end
    if (ctrl.rd_rs) begin
      a <= (w[19:15] == 5'd0) ? 32'd0 : regs[w[19:15]];
      b <= (w[24:20] == 5'd0) ? 32'd0 : regs[w[24:20]];
      a0 <= regs[10];
      a1 <= regs[11];
      k <= '0;
      ld_val <= '0;
    end
    if (ctrl.mem_step && !pre && !halt_flag) begin
      if (op == rvx_pkg::OpLd) begin
        ld_val[8*k +: 8] <= mem[byte_addr];
      end else if (op == rvx_pkg::OpSt && !bad) begin
        mem[byte_addr] <= b[8*k +: 8];
      end
      k <= k + 2'd1;
    end
    if (ctrl.finish && pre && !halt_flag) mem[rvx_pkg::MemAw'(p_addr)] <= p_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      halt_flag <= 1'b0;
      pc <= '0;
      for (int i = 0; i < 32; i++) regs[i] <= '0;
      next_pc <= '0;
      reg_written <= 1'b0;
      dest_index <= '0;
      dest_value <= '0;
      event_code <= rvx_pkg::EvNone;
      event_value <= '0;
      halted <= 1'b0;
    end else begin
      if (ctrl.clear) clr_addr <= clr_addr + 1'b1;
      if (ctrl.finish) begin
        reg_written <= 1'b0;
        dest_index <= '0;
        dest_value <= '0;
        event_code <= rvx_pkg::EvNone;
        event_value <= '0;
        next_pc <= pc;
        halted <= halt_flag;
        if (!halt_flag && !pre) begin
          if (bad) begin
            event_code <= rvx_pkg::EvInvalid;
            event_value <= w;
            halt_flag <= 1'b1;
            halted <= 1'b1;
          end else if (op == rvx_pkg::OpSys) begin
            next_pc <= pc + 32'd4;
            pc <= pc + 32'd4;
            if (a0 == 32'd1) begin
              event_code <= rvx_pkg::EvPrintInt; event_value <= a1;
            end else if (a0 == 32'd4) begin
              event_code <= rvx_pkg::EvPrintStr; event_value <= a1;
            end else if (a0 == 32'd11) begin
              event_code <= rvx_pkg::EvPrintChar; event_value <= a1;
            end else begin
              event_code <= (a0 == 32'd10) ? rvx_pkg::EvExit : rvx_pkg::EvBadCall;
              event_value <= (a0 == 32'd10) ? 32'd0 : a0;
              halt_flag <= 1'b1;
              halted <= 1'b1;
              next_pc <= pc;
              pc <= pc;
            end
          end else begin
            if (op == rvx_pkg::OpJal || (op == rvx_pkg::OpBr && take)) begin
              next_pc <= pc + ((op == rvx_pkg::OpJal) ? imm_j : imm_b);
              pc <= pc + ((op == rvx_pkg::OpJal) ? imm_j : imm_b);
            end else begin
              next_pc <= pc + 32'd4;
              pc <= pc + 32'd4;
            end
            if (wr && rd != 5'd0) begin
              regs[rd] <= alu;
              reg_written <= 1'b1;
              dest_index <= rd;
              dest_value <= alu;
            end
          end
        end
      end
    end
  end
endmodule

[hdl/rvx_ctrl.sv]
module rvx_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rvx_pkg::stat_t stat,
  output rvx_pkg::ctrl_t ctrl,
  output logic           busy,
  output logic           strobe
);
  typedef enum logic [6:0] {
    SIdle = 7'b0000001, SRead = 7'b0000010, SExec = 7'b0000100,
    SDiv = 7'b0001000, SMem = 7'b0010000, SDone = 7'b0100000,
    SClear = 7'b1000000
  } state_t;
  state_t state, state_next;

  always_comb begin
    state_next = state;
    ctrl = '0;
    case (state)
      SClear: begin
        ctrl.clear = 1'b1;
        if (stat.clear_last) state_next = SIdle;
      end
      SIdle: if (start) begin
        ctrl.decode = 1'b1; state_next = SRead;
      end
      SRead: begin
        ctrl.rd_rs = 1'b1; state_next = SExec;
      end
      SExec: begin
        if (stat.need_div) begin
          ctrl.div_start = 1'b1; state_next = SDiv;
        end else state_next = SMem;
      end
      SDiv: if (stat.div_done) state_next = SMem;
      SMem: begin
        ctrl.mem_step = 1'b1;
        if (stat.mem_last) state_next = SDone;
      end
      SDone: begin
        ctrl.finish = 1'b1; state_next = SIdle;
      end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SClear;
      strobe <= 1'b0;
    end else begin
      state <= state_next;
      strobe <= ctrl.finish;
    end
  end

  assign busy = state != SIdle;
endmodule

[hdl/rv32_instruction_execute.sv]
// From start to strobe the control steps through decode, register read, execute,
// the memory step (one per byte for loads and stores) and finish; DIV and REM also
// wait in the bit-serial divider. Only one instruction is in flight; busy is low again in the strobe cycle.
// Results are strobed for one cycle and cannot be stalled.
// Synchronous reset clears registers, PC and halt flag, then zeroes all 65536 bytes
// of data memory in a clearing pass with busy high.
`include "rv32_instruction_execute_macros.svh"
module rv32_instruction_execute (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        strobe,
  input  logic        mode,
  input  logic [31:0] instr_word,
  input  logic [15:0] preload_addr,
  input  logic [7:0]  preload_byte,
  output logic [31:0] next_pc,
  output logic        reg_written,
  output logic [4:0]  dest_index,
  output logic [31:0] dest_value,
  output logic [2:0]  event_code,
  output logic [31:0] event_value,
  output logic        halted
);
  rvx_pkg::ctrl_t ctrl;
  rvx_pkg::stat_t stat;

  rvx_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .ctrl(ctrl),
    .busy(busy), .strobe(strobe)
  );

  rvx_datapath u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat), .mode(mode),
    .instr_word(instr_word), .preload_addr(preload_addr),
    .preload_byte(preload_byte), .next_pc(next_pc), .reg_written(reg_written),
    .dest_index(dest_index), .dest_value(dest_value), .event_code(event_code),
    .event_value(event_value), .halted(halted)
  );

  `RVX_ASSERT_NEXT(a_strobe_one, strobe, !strobe)
  `RVX_ASSERT_IMPL(a_wr_nonzero, strobe && reg_written, dest_index != 5'd0)
  `RVX_ASSERT_IMPL(a_halt_ev, strobe && (event_code == rvx_pkg::EvExit || event_code == rvx_pkg::EvBadCall || event_code == rvx_pkg::EvInvalid), halted)
endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
module testbench;
  localparam int StallLimit = 200000;
  localparam logic [6:0] F7Base = 7'h00;
  localparam logic [6:0] F7Mul = 7'h01;
  localparam logic [2:0] F3Add = 3'd0, F3Sll = 3'd1, F3Slt = 3'd2, F3Xor = 3'd4;
  localparam logic [2:0] F3Srl = 3'd5, F3Or = 3'd6, F3And = 3'd7;
  localparam logic [2:0] F3Mul = 3'd0, F3Mulh = 3'd1, F3Div = 3'd4, F3Rem = 3'd6;
  localparam logic [2:0] F3Lb = 3'd0, F3Lh = 3'd1, F3Lw = 3'd2, F3Lbu = 3'd4, F3Lhu = 3'd5;
  localparam logic [2:0] F3Sb = 3'd0, F3Sh = 3'd1, F3Sw = 3'd2;
  localparam logic [2:0] F3Beq = 3'd0, F3Bne = 3'd1, F3Blt = 3'd4, F3Bge = 3'd5;
  localparam logic [2:0] F3Bltu = 3'd6, F3Bgeu = 3'd7;
  localparam logic [4:0] RegA0 = 5'd10, RegA1 = 5'd11;
  localparam logic [11:0] CallPrintInt = 12'd1, CallPrintStr = 12'd4;
  localparam logic [11:0] CallExit = 12'd10, CallPrintChar = 12'd11;

  typedef struct packed {
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic [2:0]  ev;
    logic [31:0] evv;
    logic        halted;
  } exec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic mode = 1'b0;
  logic [31:0] instr_word = '0;
  logic [15:0] preload_addr = '0;
  logic [7:0] preload_byte = '0;
  logic busy, strobe, reg_written, halted;
  logic [31:0] next_pc, dest_value, event_value;
  logic [4:0] dest_index;
  logic [2:0] event_code;

  logic [31:0] gpr [32];
  logic [31:0] pc_q;
  logic [7:0] dmem [65536];
  logic halt_q;
  exec_t pending_results [$];
  int errors = 0;
  int stall_cycles = 0;
  bit no_gaps = 1'b0;

  rv32_instruction_execute u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, rvx_pkg::OpR};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rvx_pkg::OpSt};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rvx_pkg::OpBr};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rvx_pkg::OpJal};
  endfunction

  function automatic logic [31:0] mem_word(logic [31:0] addr);
    logic [15:0] base;
    base = addr[15:0];
    return {dmem[16'(base + 3)], dmem[16'(base + 2)], dmem[16'(base + 1)], dmem[base]};
  endfunction

  function automatic exec_t predict_exec(logic md, logic [31:0] w, logic [15:0] pa,
                                         logic [7:0] pb, bit commit);
    exec_t r;
    logic [6:0] op, f7;
    logic [4:0] rd;
    logic [2:0] f3;
    logic [31:0] a, b, imm, addr, val, npc, ld;
    logic wr, bad, stop, take;
    longint sa, sb, p;
    op = w[6:0];
    rd = w[11:7];
    f3 = w[14:12];
    f7 = w[31:25];
    a = (w[19:15] == 5'd0) ? 32'd0 : gpr[w[19:15]];
    b = (w[24:20] == 5'd0) ? 32'd0 : gpr[w[24:20]];
    sa = $signed(a);
    sb = $signed(b);
    npc = pc_q + 32'd4;
    val = '0;
    wr = 1'b0;
    bad = 1'b0;
    stop = 1'b0;
    take = 1'b0;
    r = '0;
    if (halt_q || md) begin
      if (!halt_q && commit) dmem[pa] = pb;
      npc = pc_q;
    end else begin
      case (op)
        rvx_pkg::OpR: begin
          wr = 1'b1;
          if (f7 == F7Base) begin
            case (f3)
              F3Add: val = a + b;
              F3Sll: val = a << b[4:0];
              F3Slt: val = {31'd0, $signed(a) < $signed(b)};
              F3Xor: val = a ^ b;
              F3Srl: val = a >> b[4:0];
              F3Or:  val = a | b;
              F3And: val = a & b;
              default: bad = 1'b1;
            endcase
          end else if (f7 == F7Mul) begin
            case (f3)
              F3Mul: val = a * b;
              F3Mulh: begin
                p = sa * sb;
                val = p[63:32];
              end
              F3Div: begin
                if (b == 0) begin
                  val = 32'hFFFF_FFFF;
                end else begin
                  p = sa / sb;
                  val = p[31:0];
                end
              end
              F3Rem: begin
                if (b == 0) begin
                  val = a;
                end else begin
                  p = sa % sb;
                  val = p[31:0];
                end
              end
              default: bad = 1'b1;
            endcase
          end else if (f7 == rvx_pkg::F7Alt && f3 == F3Add) begin
            val = a - b;
          end else if (f7 == rvx_pkg::F7Alt && f3 == F3Srl) begin
            val = $signed(a) >>> b[4:0];
          end else begin
            bad = 1'b1;
          end
        end
        rvx_pkg::OpI: begin
          wr = 1'b1;
          imm = {{20{w[31]}}, w[31:20]};
          case (f3)
            F3Add: val = a + imm;
            F3Sll: if (f7 == F7Base) val = a << w[24:20]; else bad = 1'b1;
            F3Slt: val = {31'd0, $signed(a) < $signed(imm)};
            F3Xor: val = a ^ imm;
            F3Srl: begin
              if (f7 == F7Base) val = a >> w[24:20];
              else if (f7 == rvx_pkg::F7Alt) val = $signed(a) >>> w[24:20];
              else bad = 1'b1;
            end
            F3Or:  val = a | imm;
            F3And: val = a & imm;
            default: bad = 1'b1;
          endcase
        end
        rvx_pkg::OpSys: begin
          stop = 1'b1;
          r.evv = gpr[RegA1];
          case (gpr[RegA0])
            32'(CallPrintInt): begin r.ev = rvx_pkg::EvPrintInt; stop = 1'b0; end
            32'(CallPrintStr): begin r.ev = rvx_pkg::EvPrintStr; stop = 1'b0; end
            32'(CallPrintChar): begin r.ev = rvx_pkg::EvPrintChar; stop = 1'b0; end
            32'(CallExit): begin r.ev = rvx_pkg::EvExit; r.evv = '0; end
            default: begin r.ev = rvx_pkg::EvBadCall; r.evv = gpr[RegA0]; end
          endcase
        end
        rvx_pkg::OpBr: begin
          imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
          case (f3)
            F3Beq: take = a == b;
            F3Bne: take = a != b;
            F3Blt: take = $signed(a) < $signed(b);
            F3Bge: take = $signed(a) >= $signed(b);
            F3Bltu: take = a < b;
            F3Bgeu: take = a >= b;
            default: bad = 1'b1;
          endcase
          if (take) npc = pc_q + imm;
        end
        rvx_pkg::OpJal: begin
          imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
          wr = 1'b1;
          val = pc_q + 32'd4;
          npc = pc_q + imm;
        end
        rvx_pkg::OpSt: begin
          addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
          if (f3 <= F3Sw) begin
            if (commit)
              for (int k = 0; k < (1 << f3); k++) dmem[16'(addr[15:0] + k)] = b[8*k +: 8];
          end else begin
            bad = 1'b1;
          end
        end
        rvx_pkg::OpLd: begin
          addr = a + {{20{w[31]}}, w[31:20]};
          ld = mem_word(addr);
          wr = 1'b1;
          case (f3)
            F3Lb:  val = {{24{ld[7]}}, ld[7:0]};
            F3Lh:  val = {{16{ld[15]}}, ld[15:0]};
            F3Lw:  val = ld;
            F3Lbu: val = {24'd0, ld[7:0]};
            F3Lhu: val = {16'd0, ld[15:0]};
            default: bad = 1'b1;
          endcase
        end
        rvx_pkg::OpLui: begin
          wr = 1'b1;
          val = {w[31:12], 12'd0};
        end
        rvx_pkg::OpAuipc: begin
          wr = 1'b1;
          val = pc_q + {w[31:12], 12'd0};
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        r.ev = rvx_pkg::EvInvalid;
        r.evv = w;
        stop = 1'b1;
      end
      if (stop) begin
        wr = 1'b0;
        npc = pc_q;
      end
    end
    if (!wr || rd == 5'd0) begin
      wr = 1'b0;
      rd = '0;
      val = '0;
    end
    if (commit) begin
      if (wr) gpr[rd] = val;
      pc_q = npc;
      if (stop) halt_q = 1'b1;
    end
    r.npc = npc;
    r.wr = wr;
    r.rd = rd;
    r.val = val;
    r.halted = halt_q | stop;
    return r;
  endfunction

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 9);
    if (no_gaps || roll < 6) return 0;
    if (roll < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic send_item(logic md, logic [31:0] w, logic [15:0] pa, logic [7:0] pb);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= md;
    instr_word <= w;
    preload_addr <= pa;
    preload_byte <= pb;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_exec(md, w, pa, pb, 1'b1));
  endtask

  task automatic run_instr(logic [31:0] w);
    send_item(1'b0, w, 16'($urandom), 8'($urandom));
  endtask

  task automatic run_preload(logic [15:0] pa, logic [7:0] pb);
    send_item(1'b1, $urandom, pa, pb);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s expected %h got %h", name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    exec_t e;
    if (!rst && strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no transfer outstanding");
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("next_pc", e.npc, next_pc);
        check_field("reg_written", 32'(e.wr), 32'(reg_written));
        check_field("dest_index", 32'(e.rd), 32'(dest_index));
        check_field("dest_value", e.val, dest_value);
        check_field("event_code", 32'(e.ev), 32'(event_code));
        check_field("event_value", e.evv, event_value);
        check_field("halted", 32'(e.halted), 32'(halted));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || strobe === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [31:0] random_instr();
    logic [4:0] rd, rs1, rs2;
    logic [11:0] imm;
    logic [6:0] f7;
    logic [2:0] f3;
    rd = 5'($urandom);
    rs1 = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom);
    rs2 = 5'($urandom);
    imm = 12'($urandom);
    f3 = 3'($urandom);
    case ($urandom_range(0, 3))
      0: f7 = F7Base;
      1: f7 = F7Mul;
      2: f7 = rvx_pkg::F7Alt;
      default: f7 = 7'($urandom);
    endcase
    case ($urandom_range(0, 10))
      0, 1, 2: return enc_r(f7, rs2, rs1, f3, rd);
      3, 4: begin
        if ($urandom_range(0, 3) != 0)
          imm[11:5] = ($urandom_range(0, 1) != 0) ? rvx_pkg::F7Alt : F7Base;
        return enc_i(imm, rs1, f3, rd, rvx_pkg::OpI);
      end
      5: begin
        if ($urandom_range(0, 1) != 0) rs1 = 5'd0;
        return enc_i(imm, rs1, f3, rd, rvx_pkg::OpLd);
      end
      6: begin
        if ($urandom_range(0, 1) != 0) rs1 = 5'd0;
        return enc_s(imm, rs2, rs1, f3);
      end
      7: return enc_b(13'($urandom), rs2, rs1, f3);
      8: return enc_j(21'($urandom), rd);
      9: return {20'($urandom), rd,
                 ($urandom_range(0, 1) != 0) ? rvx_pkg::OpLui : rvx_pkg::OpAuipc};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_preload();
    run_preload(16'h0000, 8'hFF);
    run_preload(16'hFFFF, 8'h80);
    run_preload(16'hFFFE, 8'h7F);
    run_preload(16'h0001, 8'h01);
  endtask

  task automatic test_arith_corners();
    run_instr(enc_i(12'hFFF, 5'd0, F3Add, 5'd1, rvx_pkg::OpI));
    run_instr({20'h80000, 5'd2, rvx_pkg::OpLui});
    run_instr(enc_r(F7Mul, 5'd1, 5'd2, F3Div, 5'd3));
    run_instr(enc_r(F7Mul, 5'd1, 5'd2, F3Rem, 5'd4));
    run_instr(enc_r(F7Mul, 5'd0, 5'd1, F3Div, 5'd5));
    run_instr(enc_r(F7Mul, 5'd0, 5'd1, F3Rem, 5'd6));
    run_instr(enc_r(F7Mul, 5'd2, 5'd2, F3Mulh, 5'd7));
    run_instr(enc_r(rvx_pkg::F7Alt, 5'd1, 5'd2, F3Srl, 5'd8));
    run_instr(enc_i(12'h7FF, 5'd1, F3Add, 5'd0, rvx_pkg::OpI));
    run_instr(enc_r(F7Base, 5'd0, 5'd0, F3Slt, 5'd9));
  endtask

  task automatic test_memory_wrap();
    run_instr(enc_i(12'hFFE, 5'd0, F3Lw, 5'd12, rvx_pkg::OpLd));
    run_instr(enc_i(12'hFFF, 5'd0, F3Lb, 5'd13, rvx_pkg::OpLd));
    run_instr(enc_i(12'hFFF, 5'd0, F3Lhu, 5'd14, rvx_pkg::OpLd));
    run_instr(enc_s(12'hFFF, 5'd2, 5'd0, F3Sw));
    run_instr(enc_i(12'hFFF, 5'd0, F3Lw, 5'd15, rvx_pkg::OpLd));
  endtask

  task automatic test_control_flow();
    run_instr(enc_b(13'h1FF0, 5'd1, 5'd0, F3Bltu));
    run_instr(enc_b(13'h0010, 5'd2, 5'd0, F3Bge));
    run_instr(enc_j(21'h1FFFFC, 5'd1));
    run_instr({20'hFFFFF, 5'd16, rvx_pkg::OpAuipc});
    run_instr(enc_i(CallPrintInt, 5'd0, F3Add, RegA0, rvx_pkg::OpI));
    run_instr({12'd0, 5'd0, 3'd0, 5'd0, rvx_pkg::OpSys});
  endtask

  task automatic test_random(int count);
    logic [31:0] w;
    exec_t probe;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (i % 500 == 499) drain();
      case ($urandom_range(0, 19))
        0, 1: run_preload(16'($urandom), 8'($urandom));
        2: begin
          case ($urandom_range(0, 2))
            0: w = 32'(CallPrintInt);
            1: w = 32'(CallPrintStr);
            default: w = 32'(CallPrintChar);
          endcase
          run_instr(enc_i(w[11:0], 5'd0, F3Add, RegA0, rvx_pkg::OpI));
          run_instr(enc_i(12'($urandom), 5'd0, F3Add, RegA1, rvx_pkg::OpI));
          run_instr({$urandom} & 32'hFFFF_FF80 | 32'(rvx_pkg::OpSys));
        end
        default: begin
          do begin
            w = random_instr();
            probe = predict_exec(1'b0, w, '0, '0, 1'b0);
          end while (probe.halted);
          run_instr(w);
        end
      endcase
    end
  endtask

  task automatic test_halt();
    drain();
    case ($urandom_range(0, 2))
      0: begin
        run_instr(enc_i(CallExit, 5'd0, F3Add, RegA0, rvx_pkg::OpI));
        run_instr({12'd0, 5'd0, 3'd0, 5'd0, rvx_pkg::OpSys});
      end
      1: begin
        run_instr(enc_i(12'h7FF, 5'd0, F3Add, RegA0, rvx_pkg::OpI));
        run_instr({12'd0, 5'd0, 3'd0, 5'd0, rvx_pkg::OpSys});
      end
      default: run_instr(32'h0000_0000);
    endcase
    run_preload(16'h0000, 8'h55);
    run_instr(enc_i(12'h001, 5'd0, F3Add, 5'd1, rvx_pkg::OpI));
    run_instr(enc_i(12'h000, 5'd0, F3Lbu, 5'd2, rvx_pkg::OpLd));
  endtask

  initial begin
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    for (int i = 0; i < 65536; i++) dmem[i] = '0;
    pc_q = '0;
    halt_q = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_preload();
    test_arith_corners();
    test_memory_wrap();
    test_control_flow();
    drain();
    test_random(1750);
    test_halt();
    drain();
    repeat (60) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
